FILE: sv/lru_key_value_cache_defines.svh
// Assertion macros for the cache RTL
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset
`define LKV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lru cache check failed");

// Next-cycle implication, checked on aclk outside reset
`define LKV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lru cache check failed");

`endif

FILE: sv/lkv_pkg.sv
package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    // input word
    typedef struct packed {
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } lkv_in_t;

    // result word
    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } lkv_out_t;

    // one recency position of the chain
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } lkv_entry_t;

    // broadcast control for every cell
    typedef struct packed {
        logic set;   // accepted set word this cycle
        logic hit;   // key present somewhere in the chain
        logic full;  // count has reached the effective capacity
    } lkv_ctl_t;

endpackage

FILE: sv/lru_key_value_cache.sv
// LRU key-value cache.
// Input channel s_valid/s_ready/s_data carries a word {cmd, key, value}.
// cmd get looks the key up and returns one word {hit, read_value} on
// m_valid/m_ready/m_data; read_value is -1 on a miss. cmd set writes the
// value, making the entry most recent, and returns nothing; a new key is
// inserted at the front and, once capacity is reached, the least recent
// entry drops off the tail.
// Entries sit in a chain of ENTRIES cells ordered by recency; every cell
// compares its key in parallel and a set shifts the front of the chain by
// one cell, all cells together.
// A get result is registered into m_data in the cycle after acceptance.
// Throughput: one word per cycle, bounded only by the one-entry output
// register; s_ready drops while a result is held and m_ready is low.
// Reset (aresetn low, synchronous) empties the cache and sets capacity to 16.
// capacity is written via cfg_wr_en/cfg_wr_data; the user writes it only while
// idle, unenforced by the block; 0 acts as 1, values above ENTRIES act as ENTRIES.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  lkv_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lkv_out_t         m_data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]        capacity_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    lkv_out_t                m_data_reg;
    lkv_out_t                m_data_next;

    logic                    accept;
    logic                    insert_room;
    logic [CMP_W-1:0]        cap_wide;
    logic [CNT_W-1:0]        eff_cap;
    lkv_ctl_t                ctl;
    lkv_entry_t              head;
    lkv_entry_t              ent   [ENTRIES];
    logic [ENTRIES:0]        seen;
    logic [ENTRIES-1:0]      match_vec;
    logic [ENTRIES-1:0]      valid_vec;
    logic signed [VAL_W-1:0] sel_value;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // effective capacity, clamped to 1..ENTRIES
    assign cap_wide = CMP_W'(capacity_reg);
    always_comb begin
        if (cap_wide == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_wide > CMP_W'(ENTRIES)) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(cap_wide);
        end
    end

    // new entry enters at the front of the chain
    assign head = '{valid: 1'b1, key: s_data.key, value: s_data.value};
    assign seen[0] = 1'b0;

    // the end of the seen chain flags a match anywhere
    always_comb begin
        ctl.set  = accept && (s_data.cmd == CMD_SET);
        ctl.hit  = seen[ENTRIES];
        ctl.full = (count_reg >= eff_cap);
    end

    // recency chain, position 0 most recent
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        lkv_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .key      (s_data.key),
            .prev     ((i == 0) ? head : ent[(i == 0) ? 0 : i-1]),
            .seen_in  (seen[i]),
            .seen_out (seen[i+1]),
            .match    (match_vec[i]),
            .cur      (ent[i])
        );
        assign valid_vec[i] = ent[i].valid;
    end

    // at most one cell matches, so an OR picks its value
    always_comb begin
        sel_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_vec[i]) begin
                sel_value = sel_value | ent[i].value;
            end
        end
    end

    // fill count grows only on an insert with room left
    assign insert_room = ctl.set && !ctl.hit && !ctl.full;
    always_comb begin
        count_next = count_reg;
        if (insert_room) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept && (s_data.cmd == CMD_GET)) begin
            m_valid_next           = 1'b1;
            m_data_next.hit        = ctl.hit;
            m_data_next.read_value = ctl.hit ? sel_value : MISS_VALUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_W'(16);
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `LKV_ASSERT_NOW(a_match_unique, 1'b1, $onehot0(match_vec))
    `LKV_ASSERT_NOW(a_count_tracks_valid, 1'b1, $countones(valid_vec) == 32'(count_reg))
    `LKV_ASSERT_NEXT(a_insert_grows, insert_room, count_reg == $past(count_reg) + CNT_W'(1))
    `LKV_ASSERT_NEXT(a_get_result, accept && (s_data.cmd == CMD_GET), m_valid)

endmodule

FILE: sv/lkv_cell.sv
module lkv_cell
    import lkv_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lkv_ctl_t                ctl,
    input  logic signed [KEY_W-1:0] key,
    input  lkv_entry_t              prev,
    input  logic                    seen_in,
    output logic                    seen_out,
    output logic                    match,
    output lkv_entry_t              cur
);

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic                    shift;

    // compare against the broadcast key
    assign match    = valid_reg && (key_reg == key);
    assign seen_out = seen_in | match;

    // shift from the more recent neighbour: on a hit up to the matching cell,
    // on a miss up to the insert position (last in use when full, else first free)
    always_comb begin
        if (ctl.hit) begin
            shift = ctl.set && !seen_in;
        end else if (ctl.full) begin
            shift = ctl.set && valid_reg;
        end else begin
            shift = ctl.set && prev.valid;
        end
        valid_next = shift ? prev.valid : valid_reg;
        key_next   = shift ? prev.key   : key_reg;
        value_next = shift ? prev.value : value_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign cur = '{valid: valid_reg, key: key_reg, value: value_reg};

endmodule

FILE: verif/tb_lru_key_value_cache.sv
module tb_lru_key_value_cache
    import lkv_pkg::*;
();

    localparam int DEPTH          = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 150;

    logic             aclk;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    lkv_in_t          s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    lkv_out_t         m_data;

    // shadow copy of the cache contents and recency chain
    logic signed [KEY_W-1:0] shadow_key [DEPTH];
    logic signed [VAL_W-1:0] shadow_val [DEPTH];
    bit                      shadow_used [DEPTH];
    int                      shadow_order [DEPTH];
    int                      shadow_count;
    logic [CAP_W-1:0]        shadow_cap;

    lkv_out_t pending_reads[$];

    int errors      = 0;
    int idle_cycles = 0;
    int hold_req    = 0;
    bit no_idle     = 1'b0;

    logic signed [KEY_W-1:0] key_pool [64];
    int                      pool_size = 1;

    lru_key_value_cache #(.ENTRIES(DEPTH)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // mostly short gaps, a few long ones; none while no_idle is set
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // apply one accepted word to the shadow cache; a get queues its read result
    function automatic void predict_access(lkv_in_t w);
        int       pos;
        int       slot;
        int       limit;
        int       i;
        lkv_out_t r;
        pos = DEPTH;
        for (i = 0; i < shadow_count; i++) begin
            slot = shadow_order[i];
            if (pos == DEPTH && shadow_used[slot] && shadow_key[slot] == w.key) pos = i;
        end
        if (w.cmd == CMD_GET) begin
            if (pos < DEPTH) begin
                r.hit        = 1'b1;
                r.read_value = shadow_val[shadow_order[pos]];
            end else begin
                r.hit        = 1'b0;
                r.read_value = MISS_VALUE;
            end
            pending_reads.push_back(r);
            return;
        end
        // absent key: take the next free slot, or reuse the least recent one
        if (pos == DEPTH) begin
            limit = (shadow_cap == 0) ? 1 : ((shadow_cap > DEPTH) ? DEPTH : shadow_cap);
            if (shadow_count < limit) begin
                pos = shadow_count;
                shadow_count++;
            end else begin
                pos = shadow_count - 1;
            end
            slot              = shadow_order[pos];
            shadow_key[slot]  = w.key;
            shadow_used[slot] = 1'b1;
        end
        slot             = shadow_order[pos];
        shadow_val[slot] = w.value;
        for (i = pos; i > 0; i--) shadow_order[i] = shadow_order[i - 1];
        shadow_order[0] = slot;
    endfunction

    // sample both channels and the config port at the rising edge
    always @(posedge aclk) begin : monitor
        lkv_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_reads.size() == 0) begin
                    $error("unexpected result word: hit %0b read_value %0d",
                           m_data.hit, m_data.read_value);
                    errors++;
                end else begin
                    want = pending_reads.pop_front();
                    if (m_data.hit !== want.hit) begin
                        $error("hit: expected %0b, got %0b", want.hit, m_data.hit);
                        errors++;
                    end
                    if (m_data.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, m_data.read_value);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) shadow_cap = cfg_wr_data;
            if (s_valid && s_ready) predict_access(s_data);
            if ((m_valid && m_ready) || (s_valid && s_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : receiver
        int n;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                n        = hold_req;
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                n = idle_gap();
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(negedge aclk);
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // offer one word; returns at the falling edge after it is accepted
    task automatic send_word(input logic op, input logic signed [KEY_W-1:0] k,
                             input logic signed [VAL_W-1:0] v);
        int      gap;
        lkv_in_t w;
        gap     = idle_gap();
        w.cmd   = op;
        w.key   = k;
        w.value = v;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic put(input logic signed [KEY_W-1:0] k, input logic signed [VAL_W-1:0] v);
        send_word(CMD_SET, k, v);
    endtask

    task automatic get(input logic signed [KEY_W-1:0] k);
        send_word(CMD_GET, k, $urandom);
    endtask

    // stop sending and wait for every outstanding read, then let sets settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_empty_lookups();
        get(32'sh8000_0000);
        get(32'sh7fff_ffff);
        get(32'sh0000_0000);
    endtask

    // capacity 0 behaves as 1: re-setting the only entry is a value update
    task automatic test_single_entry();
        set_capacity(5'd0);
        put(32'sh0bad_cafe, 32'sh0000_0001);
        put(32'sh0bad_cafe, 32'sh0000_0002);
        get(32'sh0bad_cafe);
        put(32'sh1357_9bdf, 32'sh0000_0003);
        get(32'sh0bad_cafe);
        get(32'sh1357_9bdf);
    endtask

    // field extremes, including a stored value equal to the miss marker
    task automatic test_extreme_fields();
        set_capacity(5'd31);
        put(32'sh8000_0000, 32'sh7fff_ffff);
        put(32'sh7fff_ffff, 32'sh8000_0000);
        put(32'sh0000_0000, 32'shffff_ffff);
        get(32'sh8000_0000);
        get(32'sh7fff_ffff);
        send_word(CMD_GET, 32'sh0000_0000, 32'sh7fff_ffff);
    endtask

    // update of an older entry promotes it; the least recent one is evicted
    task automatic test_recency_order();
        set_capacity(5'd3);
        put(32'sh0000_00a1, 32'sh0000_0001);
        put(32'sh0000_00b2, 32'sh0000_0002);
        put(32'sh0000_00c3, 32'sh0000_0003);
        put(32'sh0000_00a1, 32'sh0000_0004);
        put(32'sh0000_00d4, 32'sh0000_0005);
        get(32'sh0000_00b2);
        get(32'sh0000_00a1);
        put(32'sh0000_00d4, 32'sh0000_0006);
        get(32'sh0000_00d4);
        get(32'sh0000_00c3);
    endtask

    // random gets and sets over a small key pool so hits and evictions are common
    task automatic test_random_phase(input logic [CAP_W-1:0] cap, input int n_items,
                                     input int n_keys, input bit steady, input bit fresh);
        int                      i;
        logic                    op;
        logic signed [KEY_W-1:0] k;
        set_capacity(cap);
        if (fresh) begin
            pool_size = n_keys;
            for (i = 0; i < pool_size; i++) key_pool[i] = $urandom;
        end
        no_idle = steady;
        for (i = 0; i < n_items; i++) begin
            op = $urandom_range(0, 1);
            k  = ($urandom_range(0, 9) == 0) ? $urandom
                                             : key_pool[$urandom_range(0, pool_size - 1)];
            send_word(op, k, $urandom);
        end
        no_idle = 1'b0;
    endtask

    // long receiver hold-off while words keep coming, then a full pause
    task automatic test_backpressure();
        int i;
        drain();
        hold_req = HOLD_CYCLES;
        no_idle  = 1'b1;
        for (i = 0; i < 30; i++)
            send_word((i % 3 == 0) ? CMD_SET : CMD_GET,
                      key_pool[$urandom_range(0, pool_size - 1)], $urandom);
        no_idle = 1'b0;
        drain();
    endtask

    initial begin : main
        int i;
        for (i = 0; i < DEPTH; i++) begin
            shadow_key[i]   = '0;
            shadow_val[i]   = '0;
            shadow_used[i]  = 1'b0;
            shadow_order[i] = i;
        end
        shadow_count = 0;
        shadow_cap   = 5'd16;
        key_pool[0]  = '0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_lookups();
        test_single_entry();
        test_extreme_fields();
        test_recency_order();
        test_random_phase(5'd16, 200, 24, 1'b0, 1'b1);
        // capacity below the current count, same keys
        test_random_phase(5'd4, 150, 24, 1'b0, 1'b0);
        test_backpressure();
        test_random_phase(5'd1, 100, 6, 1'b0, 1'b1);
        test_random_phase(5'd31, 200, 40, 1'b0, 1'b1);
        test_random_phase(5'd0, 80, 4, 1'b0, 1'b1);
        test_random_phase(5'd7, 200, 16, 1'b1, 1'b1);
        test_random_phase(5'd12, 265, 20, 1'b0, 1'b1);

        drain();
        repeat (8) @(negedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/lkv_pkg.sv
sv/lkv_cell.sv
sv/lru_key_value_cache.sv
verif/tb_lru_key_value_cache.sv
